@@ sv/clr_pkg.sv @@
// ----------------------------------------------------------------------------
// Clipped line rasterizer package
// Shared widths, fixed-point constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package clr_pkg;

	// Screen geometry and fixed-point format.
	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 64;
	localparam int FRAC_BITS     = 24;
	localparam int COORD_W       = 6;
	localparam int ADDR_W        = 12;
	localparam int RUN_MAX       = 64;

	// Signed working width of endpoint coordinates and deltas.
	localparam int WIDE_W  = 18;
	// Magnitude width of a clip numerator or denominator.
	localparam int MAG_W   = WIDE_W - 1;
	// Dividend and quotient width of the shared divider.
	localparam int DIVD_W  = MAG_W + FRAC_BITS;
	// Clip parameter t in [0, 1.0].
	localparam int T_W     = FRAC_BITS + 1;
	localparam int PROD_W  = T_W + MAG_W;

	localparam logic [T_W-1:0]       FX_ONE    = T_W'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] ACC_START = FRAC_BITS'((1 << (FRAC_BITS - 1)) - 1);

	// Configuration register indexes.
	localparam logic [2:0] CFG_CLIP_LEFT   = 3'd0;
	localparam logic [2:0] CFG_CLIP_TOP    = 3'd1;
	localparam logic [2:0] CFG_CLIP_RIGHT  = 3'd2;
	localparam logic [2:0] CFG_CLIP_BOTTOM = 3'd3;
	localparam logic [2:0] CFG_PALETTE     = 3'd4;

	// Sequencer states.
	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_CHECK    = 11'b000_0000_0010,
		ST_EDGE     = 11'b000_0000_0100,
		ST_DIV      = 11'b000_0000_1000,
		ST_EDGE_UPD = 11'b000_0001_0000,
		ST_MUL      = 11'b000_0010_0000,
		ST_ADD      = 11'b000_0100_0000,
		ST_SAT      = 11'b000_1000_0000,
		ST_SETUP    = 11'b001_0000_0000,
		ST_DRAW     = 11'b010_0000_0000,
		ST_REJECT   = 11'b100_0000_0000
	} state_t;

endpackage

@@ sv/clipped_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// Clipped line rasterizer
// Clips one line against a rectangle and walks it into pixel write requests.
// ----------------------------------------------------------------------------
// One line request is taken while the block is idle. A line with both ends
// inside the clip rectangle goes straight to setup; otherwise each of the
// four Liang-Barsky edges with a nonzero denominator takes one division on
// the shared restoring divider and an update step, and the four endpoint
// scalings each take a multiply step and an add step on the multiplier,
// followed by the final saturation. The slope costs one more division
// (skipped when both ends meet in one point), and then one pixel request
// leaves per cycle while the output is taken, up to 64.
// A fully clipped line yields one request with visible low. The divider is
// the unit that sets the latency.
module clipped_line_rasterizer_top (
	input  logic        clk,
	input  logic        arst_n,
	// Line request: start_x, start_y, end_x, end_y, color_select, zero fill.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,
	// Pixel request: pixel_address, pixel_value, zero fill.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	// visible
	output logic        m_axis_tuser,
	// last_pixel
	output logic        m_axis_tlast,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int W  = clr_pkg::WIDE_W;
	localparam int MW = clr_pkg::MAG_W;
	localparam int FB = clr_pkg::FRAC_BITS;
	localparam int CW = clr_pkg::COORD_W;

	clr_pkg::state_t state_q;

	// Configuration registers.
	logic [CW-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic [63:0]   palette_q;

	// Line registers.
	logic signed [W-1:0] ax_q, ay_q, bx_q, by_q, dx_q, dy_q;
	logic [8:0]          sel_q;
	logic [1:0]          k_q;
	logic [clr_pkg::T_W-1:0] te_q, tl_q;
	logic                neg_q, den_pos_q, div_slope_q;

	// Shared divider.
	logic [clr_pkg::DIVD_W-1:0] quo_q;
	logic [MW-1:0]              rem_q, dvs_q;
	logic [5:0]                 cnt_q;

	// Shared multiplier.
	logic [clr_pkg::PROD_W-1:0] prod_q;
	logic                       dneg_q;

	// Line walk.
	logic [CW:0]     mj_q, mn_q;
	logic [CW-1:0]   n_q, i_q;
	logic [FB-1:0]   acc_q;
	logic [FB:0]     slope_q;
	logic            xmaj_q, dir_neg_q;
	logic [2:0]      pal_q;

	// Output register.
	logic                      out_valid_q;
	logic [clr_pkg::ADDR_W-1:0] out_addr_q;
	logic [7:0]                out_val_q;
	logic                      out_vis_q, out_last_q;

	logic out_free, draw_fire, rej_fire, in_fire;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == clr_pkg::ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign draw_fire     = (state_q == clr_pkg::ST_DRAW) && out_free;
	assign rej_fire      = (state_q == clr_pkg::ST_REJECT) && out_free;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_val_q, out_addr_q};
	assign m_axis_tuser  = out_vis_q;
	assign m_axis_tlast  = out_last_q;

	// Clip bounds widened to the signed working width.
	logic signed [W-1:0] lo_x, hi_x, lo_y, hi_y;
	assign lo_x = $signed({{(W-CW){1'b0}}, clip_left_q});
	assign hi_x = $signed({{(W-CW){1'b0}}, clip_right_q});
	assign lo_y = $signed({{(W-CW){1'b0}}, clip_top_q});
	assign hi_y = $signed({{(W-CW){1'b0}}, clip_bottom_q});

	// Saturate a coordinate into [lo, hi]; the lower bound wins.
	function automatic logic signed [W-1:0] sat_c(input logic signed [W-1:0] v,
			input logic signed [W-1:0] lo, input logic signed [W-1:0] hi);
		logic signed [W-1:0] r;
		r = (v > hi) ? hi : v;
		r = (r < lo) ? lo : r;
		return r;
	endfunction

	// Outside test on the original endpoints.
	logic out_a, out_b;
	assign out_a = ax_q < lo_x || ax_q > hi_x || ay_q < lo_y || ay_q > hi_y;
	assign out_b = bx_q < lo_x || bx_q > hi_x || by_q < lo_y || by_q > hi_y;

	// Numerator and denominator of the current clip edge.
	logic signed [W-1:0] e_num, e_den, e_num_abs, e_den_abs;
	always_comb begin
		case (k_q)
			2'd0: begin
				e_num = lo_x - ax_q;
				e_den = dx_q;
			end
			2'd1: begin
				e_num = ax_q - hi_x;
				e_den = -dx_q;
			end
			2'd2: begin
				e_num = lo_y - ay_q;
				e_den = dy_q;
			end
			default: begin
				e_num = ay_q - hi_y;
				e_den = -dy_q;
			end
		endcase
		e_num_abs = e_num[W-1] ? -e_num : e_num;
		e_den_abs = e_den[W-1] ? -e_den : e_den;
	end

	// Divider step.
	logic [MW:0] div_tmp;
	logic        div_ge;
	assign div_tmp = {rem_q, quo_q[clr_pkg::DIVD_W-1]};
	assign div_ge  = div_tmp >= {1'b0, dvs_q};

	// Signed clip parameter from the quotient.
	logic signed [clr_pkg::DIVD_W:0] t_val, te_ext, tl_ext;
	assign t_val  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign te_ext = $signed({{(clr_pkg::DIVD_W+1-clr_pkg::T_W){1'b0}}, te_q});
	assign tl_ext = $signed({{(clr_pkg::DIVD_W+1-clr_pkg::T_W){1'b0}}, tl_q});

	// Multiplier operands and the scaled offset.
	logic [clr_pkg::T_W-1:0] m_t;
	logic signed [W-1:0]     m_d, m_base, m_delta, m_sum;
	logic [MW-1:0]           m_dabs;
	always_comb begin
		m_t     = k_q[1] ? te_q : tl_q;
		m_d     = k_q[0] ? dy_q : dx_q;
		m_dabs  = MW'(m_d[W-1] ? -m_d : m_d);
		m_base  = k_q[0] ? ay_q : ax_q;
		m_delta = dneg_q ? -$signed(prod_q[clr_pkg::PROD_W-1:FB])
				: $signed(prod_q[clr_pkg::PROD_W-1:FB]);
		m_sum   = m_base + m_delta;
	end

	// Setup of the walk from clipped endpoints.
	logic [CW-1:0] x0, y0, x1, y1, hh, vv, sx, sy, ex, ey;
	logic          xmaj, swp;
	always_comb begin
		x0   = ax_q[CW-1:0];
		y0   = ay_q[CW-1:0];
		x1   = bx_q[CW-1:0];
		y1   = by_q[CW-1:0];
		hh   = (x1 > x0) ? x1 - x0 : x0 - x1;
		vv   = (y1 > y0) ? y1 - y0 : y0 - y1;
		xmaj = hh >= vv;
		swp  = xmaj ? (x0 > x1) : (y0 > y1);
		sx   = swp ? x1 : x0;
		sy   = swp ? y1 : y0;
		ex   = swp ? x0 : x1;
		ey   = swp ? y0 : y1;
	end

	// Current pixel.
	logic [CW-1:0]             px, py;
	logic [clr_pkg::ADDR_W-1:0] p_addr;
	logic [7:0]                p_val;
	logic [FB:0]               acc_sum;
	always_comb begin
		px      = xmaj_q ? mj_q[CW-1:0] : mn_q[CW-1:0];
		py      = xmaj_q ? mn_q[CW-1:0] : mj_q[CW-1:0];
		p_addr  = clr_pkg::ADDR_W'(clr_pkg::ADDR_W'(py) * clr_pkg::ADDR_W'(clr_pkg::SCREEN_WIDTH))
				+ clr_pkg::ADDR_W'(px);
		p_val   = sel_q[8] ? palette_q[8*pal_q +: 8] : sel_q[7:0];
		acc_sum = {1'b0, acc_q} + slope_q;
	end

	// Sequencer, output valid and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= clr_pkg::ST_IDLE;
			out_valid_q   <= 1'b0;
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= '1;
			clip_bottom_q <= '1;
			palette_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					clr_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_data[CW-1:0];
					clr_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_data[CW-1:0];
					clr_pkg::CFG_CLIP_RIGHT:  clip_right_q  <= cfg_data[CW-1:0];
					clr_pkg::CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_data[CW-1:0];
					clr_pkg::CFG_PALETTE:     palette_q     <= cfg_data;
					default: ;
				endcase
			end
			if (draw_fire || rej_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				clr_pkg::ST_IDLE: begin
					if (in_fire) state_q <= clr_pkg::ST_CHECK;
				end
				clr_pkg::ST_CHECK: begin
					if (!out_a && !out_b) state_q <= clr_pkg::ST_SETUP;
					else if (ax_q == bx_q && ay_q == by_q) state_q <= clr_pkg::ST_REJECT;
					else state_q <= clr_pkg::ST_EDGE;
				end
				clr_pkg::ST_EDGE: begin
					if (e_den != '0) state_q <= clr_pkg::ST_DIV;
					else if (e_num > 0) state_q <= clr_pkg::ST_REJECT;
					else if (k_q == 2'd3) state_q <= clr_pkg::ST_MUL;
				end
				clr_pkg::ST_DIV: begin
					if (cnt_q == 6'd1) begin
						state_q <= div_slope_q ? clr_pkg::ST_DRAW : clr_pkg::ST_EDGE_UPD;
					end
				end
				clr_pkg::ST_EDGE_UPD: begin
					if (den_pos_q ? (t_val > tl_ext) : (t_val < te_ext)) begin
						state_q <= clr_pkg::ST_REJECT;
					end else begin
						state_q <= (k_q == 2'd3) ? clr_pkg::ST_MUL : clr_pkg::ST_EDGE;
					end
				end
				clr_pkg::ST_MUL: state_q <= clr_pkg::ST_ADD;
				clr_pkg::ST_ADD: begin
					state_q <= (k_q == 2'd3) ? clr_pkg::ST_SAT : clr_pkg::ST_MUL;
				end
				clr_pkg::ST_SAT: state_q <= clr_pkg::ST_SETUP;
				clr_pkg::ST_SETUP: begin
					state_q <= (xmaj && hh == '0) ? clr_pkg::ST_DRAW : clr_pkg::ST_DIV;
				end
				clr_pkg::ST_DRAW: begin
					if (draw_fire && i_q == n_q) state_q <= clr_pkg::ST_IDLE;
				end
				clr_pkg::ST_REJECT: begin
					if (rej_fire) state_q <= clr_pkg::ST_IDLE;
				end
				default: state_q <= clr_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			clr_pkg::ST_IDLE: begin
				if (in_fire) begin
					ax_q  <= W'($signed(s_axis_tdata[15:0]));
					ay_q  <= W'($signed(s_axis_tdata[31:16]));
					bx_q  <= W'($signed(s_axis_tdata[47:32]));
					by_q  <= W'($signed(s_axis_tdata[63:48]));
					sel_q <= s_axis_tdata[72:64];
				end
			end
			clr_pkg::ST_CHECK: begin
				dx_q <= bx_q - ax_q;
				dy_q <= by_q - ay_q;
				k_q  <= 2'd0;
				te_q <= '0;
				tl_q <= clr_pkg::FX_ONE;
			end
			clr_pkg::ST_EDGE: begin
				// Start the divider on |num| << FB / |den|.
				quo_q       <= {e_num_abs[MW-1:0], {FB{1'b0}}};
				rem_q       <= '0;
				dvs_q       <= e_den_abs[MW-1:0];
				cnt_q       <= 6'(clr_pkg::DIVD_W);
				neg_q       <= e_num[W-1] ^ e_den[W-1];
				den_pos_q   <= !e_den[W-1];
				div_slope_q <= 1'b0;
				if (e_den == '0 && e_num <= 0) k_q <= k_q + 2'd1;
			end
			clr_pkg::ST_DIV: begin
				rem_q <= div_ge ? MW'(div_tmp - {1'b0, dvs_q}) : div_tmp[MW-1:0];
				quo_q <= {quo_q[clr_pkg::DIVD_W-2:0], div_ge};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1 && div_slope_q) begin
					slope_q <= {quo_q[FB-1:0], div_ge};
				end
			end
			clr_pkg::ST_EDGE_UPD: begin
				if (den_pos_q) begin
					if (t_val <= tl_ext && t_val > te_ext) te_q <= t_val[clr_pkg::T_W-1:0];
				end else begin
					if (t_val >= te_ext && t_val < tl_ext) tl_q <= t_val[clr_pkg::T_W-1:0];
				end
				k_q <= k_q + 2'd1;
			end
			clr_pkg::ST_MUL: begin
				prod_q <= clr_pkg::PROD_W'(m_t) * clr_pkg::PROD_W'(m_dabs);
				dneg_q <= m_d[W-1];
			end
			clr_pkg::ST_ADD: begin
				// End point scales by tL first, then start point by tE.
				case (k_q)
					2'd0:    bx_q <= m_sum;
					2'd1:    by_q <= m_sum;
					2'd2:    ax_q <= m_sum;
					default: ay_q <= m_sum;
				endcase
				k_q <= k_q + 2'd1;
			end
			clr_pkg::ST_SAT: begin
				ax_q <= sat_c(ax_q, lo_x, hi_x);
				bx_q <= sat_c(bx_q, lo_x, hi_x);
				ay_q <= sat_c(ay_q, lo_y, hi_y);
				by_q <= sat_c(by_q, lo_y, hi_y);
			end
			clr_pkg::ST_SETUP: begin
				xmaj_q    <= xmaj;
				mj_q      <= {1'b0, xmaj ? sx : sy};
				mn_q      <= {1'b0, xmaj ? sy : sx};
				dir_neg_q <= xmaj ? (sy > ey) : (sx > ex);
				n_q       <= xmaj ? hh : vv;
				i_q       <= '0;
				acc_q     <= clr_pkg::ACC_START;
				pal_q     <= '0;
				slope_q   <= '0;
				quo_q     <= {{(MW-CW){1'b0}}, (xmaj ? vv : hh), {FB{1'b0}}};
				rem_q     <= '0;
				dvs_q     <= {{(MW-CW){1'b0}}, (xmaj ? hh : vv)};
				cnt_q     <= 6'(clr_pkg::DIVD_W);
				div_slope_q <= 1'b1;
			end
			clr_pkg::ST_DRAW: begin
				if (draw_fire) begin
					out_addr_q <= p_addr;
					out_val_q  <= p_val;
					out_vis_q  <= 1'b1;
					out_last_q <= (i_q == n_q);
					pal_q      <= pal_q + 3'd1;
					i_q        <= i_q + 1'b1;
					mj_q       <= mj_q + 1'b1;
					acc_q      <= acc_sum[FB-1:0];
					if (acc_sum[FB]) mn_q <= dir_neg_q ? mn_q - 1'b1 : mn_q + 1'b1;
				end
			end
			clr_pkg::ST_REJECT: begin
				if (rej_fire) begin
					out_addr_q <= '0;
					out_val_q  <= '0;
					out_vis_q  <= 1'b0;
					out_last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Checks.
	a_clip_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clr_pkg::ST_MUL) |-> (te_q <= tl_q && tl_q <= clr_pkg::FX_ONE))
		else $error("clip parameters out of order");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clr_pkg::ST_DIV) |-> (dvs_q != '0))
		else $error("divider started with zero divisor");
	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
		else $error("rejected line must be a single final request");
	a_walk_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clr_pkg::ST_DRAW) |-> (!mj_q[CW] && !mn_q[CW]))
		else $error("walk left the screen");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clipped line rasterizer testbench
// Sends line requests through the stream port and checks every pixel request
// against a behavioral predictor. The predictor follows the clip, saturation
// and slope walk bit for bit. Clip windows and the palette are changed
// between phases, both sides idle at random, and the output is held off for
// a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [8:0] PALETTE_SEL = 9'd256;

	typedef struct {
		logic [11:0] addr;
		logic [7:0]  value;
		logic        visible;
		logic        last;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	// Register copies used by the predictor.
	longint      win_left, win_top, win_right, win_bottom;
	logic [63:0] palette;

	pixel_t pixel_q[$];
	int     errors;
	int     burst_left;
	bit     no_gaps;
	int     holdoff_left;
	int     stall_mode;

	clipped_line_rasterizer_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// One Liang-Barsky boundary; narrows the entry and leave parameters.
	function automatic bit clip_bound(longint num, longint den,
			inout longint t_in, inout longint t_out);
		longint an, ad, t;
		if (den == 0)
			return num <= 0;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		t = (an << clr_pkg::FRAC_BITS) / ad;
		if ((num < 0) != (den < 0))
			t = -t;
		if (den > 0) begin
			if (t > t_out)
				return 0;
			if (t > t_in)
				t_in = t;
		end else begin
			if (t < t_in)
				return 0;
			if (t < t_out)
				t_out = t;
		end
		return 1;
	endfunction

	// t * d with the product truncated toward zero.
	function automatic longint scale_delta(longint t, longint d);
		longint p;
		p = t * d;
		return p >= 0 ? (p >>> clr_pkg::FRAC_BITS) : -((-p) >>> clr_pkg::FRAC_BITS);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v;
	endfunction

	function automatic bit off_window(longint x, longint y);
		return x < win_left || x > win_right || y < win_top || y > win_bottom;
	endfunction

	// Works out the pixel requests of one line and queues them.
	function automatic void predict_line(logic [79:0] d);
		longint ax, ay, bx, by, dx, dy, t_in, t_out, h, v, tmp, n, dir;
		bit ok, x_major;
		int unsigned slope, acc, pal_idx;
		logic [8:0] sel;
		pixel_t p;
		ax = longint'($signed(d[15:0]));
		ay = longint'($signed(d[31:16]));
		bx = longint'($signed(d[47:32]));
		by = longint'($signed(d[63:48]));
		sel = d[72:64];
		if (off_window(ax, ay) || off_window(bx, by)) begin
			dx = bx - ax;
			dy = by - ay;
			t_in = 0;
			t_out = longint'(1) << clr_pkg::FRAC_BITS;
			ok = !(ax == bx && ay == by);
			if (ok) ok = clip_bound(win_left - ax, dx, t_in, t_out);
			if (ok) ok = clip_bound(ax - win_right, -dx, t_in, t_out);
			if (ok) ok = clip_bound(win_top - ay, dy, t_in, t_out);
			if (ok) ok = clip_bound(ay - win_bottom, -dy, t_in, t_out);
			if (!ok) begin
				p.addr = '0;
				p.value = '0;
				p.visible = 1'b0;
				p.last = 1'b1;
				pixel_q.push_back(p);
				return;
			end
			if (t_out < (longint'(1) << clr_pkg::FRAC_BITS)) begin
				bx = ax + scale_delta(t_out, dx);
				by = ay + scale_delta(t_out, dy);
			end
			if (t_in > 0) begin
				ax += scale_delta(t_in, dx);
				ay += scale_delta(t_in, dy);
			end
			ax = clamp(ax, win_left, win_right);
			bx = clamp(bx, win_left, win_right);
			ay = clamp(ay, win_top, win_bottom);
			by = clamp(by, win_top, win_bottom);
		end
		h = bx > ax ? bx - ax : ax - bx;
		v = by > ay ? by - ay : ay - by;
		x_major = h >= v;
		if (x_major ? (ax > bx) : (ay > by)) begin
			tmp = ax; ax = bx; bx = tmp;
			tmp = ay; ay = by; by = tmp;
		end
		if (x_major) begin
			slope = h != 0 ? (int'(v) << clr_pkg::FRAC_BITS) / int'(h) : 0;
			n = h;
			dir = ay > by ? -1 : 1;
		end else begin
			slope = (int'(h) << clr_pkg::FRAC_BITS) / int'(v);
			n = v;
			dir = ax > bx ? -1 : 1;
		end
		if (n > clr_pkg::RUN_MAX - 1)
			n = clr_pkg::RUN_MAX - 1;
		acc = clr_pkg::ACC_START;
		pal_idx = 0;
		for (longint i = 0; i <= n; i++) begin
			p.addr = 12'(ay * clr_pkg::SCREEN_WIDTH + ax);
			if (sel[8]) begin
				p.value = palette[8*pal_idx +: 8];
				pal_idx = (pal_idx + 1) % 8;
			end else begin
				p.value = sel[7:0];
			end
			p.visible = 1'b1;
			p.last = (i == n);
			pixel_q.push_back(p);
			acc += slope;
			if (x_major)
				ax += 1;
			else
				ay += 1;
			if ((acc >> clr_pkg::FRAC_BITS) != 0) begin
				if (x_major)
					ay += dir;
				else
					ax += dir;
			end
			acc &= (1 << clr_pkg::FRAC_BITS) - 1;
		end
	endfunction

	// Offers one line request and predicts its pixels once it is taken.
	task automatic send_line(logic signed [15:0] x0, logic signed [15:0] y0,
			logic signed [15:0] x1, logic signed [15:0] y1, logic [8:0] sel);
		logic [79:0] d;
		d = {7'b0, sel, y1, x1, y0, x0};
		s_axis_tdata = d;
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_line(d);
		@(negedge clk);
		if (no_gaps || burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(0, 20);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pixel_q.size() != 0)
			@(negedge clk);
		// The block may still be returning to idle after its last request.
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		wait_drained();
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			clr_pkg::CFG_CLIP_LEFT:   win_left = value[5:0];
			clr_pkg::CFG_CLIP_TOP:    win_top = value[5:0];
			clr_pkg::CFG_CLIP_RIGHT:  win_right = value[5:0];
			clr_pkg::CFG_CLIP_BOTTOM: win_bottom = value[5:0];
			clr_pkg::CFG_PALETTE:     palette = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_window(int l, int t, int r, int b);
		write_reg(clr_pkg::CFG_CLIP_LEFT, 64'(l));
		write_reg(clr_pkg::CFG_CLIP_TOP, 64'(t));
		write_reg(clr_pkg::CFG_CLIP_RIGHT, 64'(r));
		write_reg(clr_pkg::CFG_CLIP_BOTTOM, 64'(b));
	endtask

	// Mostly near the screen, sometimes anywhere in the 16-bit range.
	function automatic logic [15:0] rand_coord();
		if ($urandom_range(0, 9) < 8)
			return 16'($signed($urandom_range(0, 100)) - 18);
		return 16'($urandom);
	endfunction

	function automatic logic [8:0] rand_select();
		case ($urandom_range(0, 3))
			0: return PALETTE_SEL;
			1: return 9'($urandom_range(256, 511));
			default: return 9'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_line();
		send_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_select());
	endtask

	// Field extremes, select kinds and each special case at reset settings.
	task automatic test_directed();
		write_reg(clr_pkg::CFG_PALETTE, 64'hF0E1_D2C3_B4A5_9687);
		send_line(5, 7, 5, 7, 9'd0);
		send_line(0, 0, 63, 0, 9'd255);
		send_line(63, 63, 0, 63, PALETTE_SEL);
		send_line(10, 0, 10, 63, 9'd511);
		send_line(0, 0, 63, 63, 9'd300);
		send_line(63, 0, 0, 63, 9'h0AA);
		send_line(3, 60, 20, 2, PALETTE_SEL);
		send_line(50, 40, 2, 30, 9'h055);
		send_line(-32768, -32768, -32768, -32768, 9'd1);
		send_line(32767, 32767, 32767, 32767, 9'd2);
		send_line(-32768, -32768, 32767, 32767, PALETTE_SEL);
		send_line(32767, -32768, -32768, 32767, 9'd3);
		send_line(-5, 10, 100, 30, 9'd4);
		send_line(70, 70, 90, 100, 9'd5);
		send_line(-10, -10, -1, -40, 9'd6);
		send_line(30, -20, 30, 80, 9'd7);
		send_line(-20, 5, 80, 5, 9'd8);
		send_line(-1, 64, 64, -1, PALETTE_SEL);
		send_line(40, 20, -300, 21, 9'd9);
		send_line(0, 0, 64, 64, 9'hFF);
	endtask

	// Several windows, extremes among them, with random lines in each.
	task automatic test_clip_settings();
		set_window(10, 20, 40, 30);
		write_reg(clr_pkg::CFG_PALETTE, 64'hFFFF_FFFF_FFFF_FFFF);
		repeat (12) send_random_line();
		send_line(0, 25, 63, 25, PALETTE_SEL);
		send_line(25, 0, 25, 63, 9'd17);
		set_window(63, 63, 63, 63);
		repeat (6) send_random_line();
		send_line(0, 0, 63, 63, 9'd18);
		set_window(0, 0, 0, 0);
		repeat (6) send_random_line();
		set_window(40, 50, 20, 10);
		repeat (8) send_random_line();
		send_line(-5, -5, 70, 70, PALETTE_SEL);
		set_window($urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, 63), $urandom_range(0, 63));
		write_reg(clr_pkg::CFG_PALETTE, {$urandom, $urandom});
		repeat (10) send_random_line();
		set_window(0, 0, 63, 63);
		write_reg(clr_pkg::CFG_PALETTE, 64'h0);
		repeat (6) send_random_line();
	endtask

	// Random lines with a pause for a full drain in the middle.
	task automatic test_random();
		write_reg(clr_pkg::CFG_PALETTE, {$urandom, $urandom});
		repeat (62) send_random_line();
		wait_drained();
		set_window($urandom_range(0, 20), $urandom_range(0, 20),
			$urandom_range(40, 63), $urandom_range(40, 63));
		repeat (62) send_random_line();
	endtask

	// Output held off while requests keep coming, so the input stalls.
	task automatic test_backpressure();
		wait_drained();
		no_gaps = 1'b1;
		holdoff_left = 600;
		repeat (15) send_random_line();
		no_gaps = 1'b0;
	endtask

	// Receiver readiness: a long hold-off when asked, else a changing pattern.
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= $urandom_range(0, 1);
				default: m_axis_tready <= $urandom_range(0, 9) == 0;
			endcase
		end
	end

	// Compares each accepted pixel request with the oldest prediction.
	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pixel_q.size() == 0) begin
				$display("%0t: unexpected pixel request addr=%0d value=%0d", $time,
					m_axis_tdata[11:0], m_axis_tdata[19:12]);
				errors++;
			end else begin
				exp_px = pixel_q.pop_front();
				if (m_axis_tdata[11:0] !== exp_px.addr) begin
					$display("%0t: pixel_address expected %0d actual %0d", $time,
						exp_px.addr, m_axis_tdata[11:0]);
					errors++;
				end
				if (m_axis_tdata[19:12] !== exp_px.value) begin
					$display("%0t: pixel_value expected %0d actual %0d", $time,
						exp_px.value, m_axis_tdata[19:12]);
					errors++;
				end
				if (m_axis_tdata[23:20] !== 4'b0) begin
					$display("%0t: tdata fill expected 0 actual %0h", $time,
						m_axis_tdata[23:20]);
					errors++;
				end
				if (m_axis_tuser !== exp_px.visible) begin
					$display("%0t: visible expected %0b actual %0b", $time,
						exp_px.visible, m_axis_tuser);
					errors++;
				end
				if (m_axis_tlast !== exp_px.last) begin
					$display("%0t: last_pixel expected %0b actual %0b", $time,
						exp_px.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		#60_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		errors = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		holdoff_left = 0;
		stall_mode = 0;
		m_axis_tready = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = clr_pkg::CFG_CLIP_LEFT;
		cfg_data = '0;
		win_left = 0;
		win_top = 0;
		win_right = 63;
		win_bottom = 63;
		palette = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_directed();
		test_backpressure();
		test_clip_settings();
		test_random();

		s_axis_tvalid = 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && pixel_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/clr_pkg.sv
sv/clipped_line_rasterizer_top.sv
tb/tb_top.sv
